// ----- src/bsa_pkg.sv -----
// shared types and codes for the four-bit bit-slice alu
package bsa_pkg;

  localparam int unsigned NibW     = 4;
  localparam int unsigned RfDepth  = 16;
  localparam int unsigned RfAddrW  = $clog2(RfDepth);

  typedef logic [NibW-1:0]    nib_t;
  typedef logic [RfAddrW-1:0] rf_addr_t;

  // operand source codes
  localparam logic [2:0] SrcAQ = 3'd0;
  localparam logic [2:0] SrcAB = 3'd1;
  localparam logic [2:0] SrcZQ = 3'd2;
  localparam logic [2:0] SrcZB = 3'd3;
  localparam logic [2:0] SrcZA = 3'd4;
  localparam logic [2:0] SrcDA = 3'd5;
  localparam logic [2:0] SrcDQ = 3'd6;
  localparam logic [2:0] SrcDZ = 3'd7;

  // function codes
  localparam logic [2:0] FnAdd  = 3'd0;
  localparam logic [2:0] FnSubR = 3'd1;
  localparam logic [2:0] FnSubS = 3'd2;
  localparam logic [2:0] FnOr   = 3'd3;
  localparam logic [2:0] FnAnd  = 3'd4;
  localparam logic [2:0] FnNotRs = 3'd5;
  localparam logic [2:0] FnXor  = 3'd6;
  localparam logic [2:0] FnXnor = 3'd7;

  // destination codes
  localparam logic [2:0] DstQReg  = 3'd0;
  localparam logic [2:0] DstNop   = 3'd1;
  localparam logic [2:0] DstRamA  = 3'd2;
  localparam logic [2:0] DstRamF  = 3'd3;
  localparam logic [2:0] DstRamQd = 3'd4;
  localparam logic [2:0] DstRamD  = 3'd5;
  localparam logic [2:0] DstRamQu = 3'd6;
  localparam logic [2:0] DstRamU  = 3'd7;

  typedef struct packed {
    rf_addr_t   addr_a;
    rf_addr_t   addr_b;
    nib_t       data_d;
    logic [2:0] source_code;
    logic [2:0] func_code;
    logic [2:0] dest_code;
    logic       carry_in;
  } in_item_t;

  typedef struct packed {
    nib_t y_out;
    logic sign_f3;
    logic zero_flag;
    logic carry_out;
    logic overflow;
    logic gen_n;
    logic prop_n;
  } out_item_t;

  typedef struct packed {
    out_item_t res;
    logic      q_we;
    nib_t      q_wdata;
    logic      rf_we;
    nib_t      rf_wdata;
  } alu_res_t;

endpackage

// ----- src/bsa_regfile.sv -----
// sixteen-entry register file, two registered read ports with write bypass
module bsa_regfile
  import bsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rd_en_i,
  input  rf_addr_t rd_addr_a_i,
  input  rf_addr_t rd_addr_b_i,
  input  logic     wr_en_i,
  input  rf_addr_t wr_addr_i,
  input  nib_t     wr_data_i,
  output nib_t     rd_data_a_o,
  output nib_t     rd_data_b_o
);

  nib_t               mem [RfDepth];
  logic [RfDepth-1:0] valid_q;
  nib_t               rd_a_q;
  nib_t               rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_a_i)) begin
        rd_a_q <= wr_data_i;
      end else if (valid_q[rd_addr_a_i]) begin
        rd_a_q <= mem[rd_addr_a_i];
      end else begin
        rd_a_q <= '0;
      end
      if (wr_en_i && (wr_addr_i == rd_addr_b_i)) begin
        rd_b_q <= wr_data_i;
      end else if (valid_q[rd_addr_b_i]) begin
        rd_b_q <= mem[rd_addr_b_i];
      end else begin
        rd_b_q <= '0;
      end
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ----- src/bsa_alu.sv -----
// operand select, alu function, status flags and destination write data
module bsa_alu
  import bsa_pkg::*;
(
  input  in_item_t item_i,
  input  nib_t     ra_i,
  input  nib_t     rb_i,
  input  nib_t     q_i,
  output alu_res_t res_o
);

  nib_t        r;
  nib_t        s;
  nib_t        rr;
  nib_t        ss;
  nib_t        p;
  nib_t        g;
  nib_t        f;
  logic [NibW:0] sum;
  logic [3:0]  sum_lo;
  logic        cn;
  logic        c4;
  logic        ovr;
  logic        gn;
  logic        pn;
  logic        t;
  logic        x;
  logic        x2;
  logic        allp;
  logic        anyg;

  assign cn = item_i.carry_in;

  always_comb begin
    case (item_i.source_code)
      SrcAQ:   begin r = ra_i;          s = q_i;  end
      SrcAB:   begin r = ra_i;          s = rb_i; end
      SrcZQ:   begin r = '0;            s = q_i;  end
      SrcZB:   begin r = '0;            s = rb_i; end
      SrcZA:   begin r = '0;            s = ra_i; end
      SrcDA:   begin r = item_i.data_d; s = ra_i; end
      SrcDQ:   begin r = item_i.data_d; s = q_i;  end
      default: begin r = item_i.data_d; s = '0;   end
    endcase
  end

  always_comb begin
    rr = ((item_i.func_code == FnSubR) || (item_i.func_code == FnNotRs) ||
          (item_i.func_code == FnXor)) ? ~r : r;
    ss = (item_i.func_code == FnSubS) ? ~s : s;
    p  = rr | ss;
    g  = rr & ss;
    sum    = {1'b0, rr} + {1'b0, ss} + {{NibW{1'b0}}, cn};
    sum_lo = {1'b0, rr[2:0]} + {1'b0, ss[2:0]} + {3'b000, cn};
    allp   = &p;
    anyg   = |g;
    t  = 1'b0;
    x  = 1'b0;
    x2 = 1'b0;
    case (item_i.func_code)
      FnAdd, FnSubR, FnSubS: begin
        f   = sum[NibW-1:0];
        c4  = sum[NibW];
        ovr = sum_lo[3] ^ sum[NibW];
        pn  = ~allp;
        t   = g[3] | (p[3] & (g[2] | (p[2] & (g[1] | (p[1] & g[0])))));
        gn  = ~t;
      end
      FnOr: begin
        f   = r | s;
        pn  = 1'b0;
        gn  = allp;
        c4  = ~allp | cn;
        ovr = c4;
      end
      FnAnd, FnNotRs: begin
        f   = g;
        pn  = 1'b0;
        gn  = ~anyg;
        c4  = anyg | cn;
        ovr = c4;
      end
      default: begin
        f   = (item_i.func_code == FnXor) ? (r ^ s) : ~(r ^ s);
        pn  = anyg;
        gn  = g[3] | (p[3] & (g[2] | (p[2] & (g[1] | (p[1] & p[0])))));
        t   = g[3] | (p[3] & (g[2] | (p[2] & (g[1] |
              (p[1] & p[0] & (g[0] | ~cn))))));
        c4  = ~t;
        x   = ~p[1] | (~g[1] & (~p[0] | (~g[0] & cn)));
        x2  = ~p[2] | (~g[2] & x);
        ovr = x2 ^ (~p[3] | (~g[3] & x2));
      end
    endcase
  end

  always_comb begin
    res_o.res.y_out     = (item_i.dest_code == DstRamA) ? ra_i : f;
    res_o.res.sign_f3   = f[NibW-1];
    res_o.res.zero_flag = (f == '0);
    res_o.res.carry_out = c4;
    res_o.res.overflow  = ovr;
    res_o.res.gen_n     = gn;
    res_o.res.prop_n    = pn;
    res_o.q_we     = 1'b0;
    res_o.q_wdata  = q_i;
    res_o.rf_we    = 1'b1;
    res_o.rf_wdata = f;
    case (item_i.dest_code)
      DstQReg: begin
        res_o.q_we    = 1'b1;
        res_o.q_wdata = f;
        res_o.rf_we   = 1'b0;
      end
      DstNop: begin
        res_o.rf_we = 1'b0;
      end
      DstRamA, DstRamF: begin
        res_o.rf_wdata = f;
      end
      DstRamQd: begin
        res_o.q_we     = 1'b1;
        res_o.q_wdata  = {1'b0, q_i[NibW-1:1]};
        res_o.rf_wdata = {1'b0, f[NibW-1:1]};
      end
      DstRamD: begin
        res_o.rf_wdata = {1'b0, f[NibW-1:1]};
      end
      DstRamQu: begin
        res_o.q_we     = 1'b1;
        res_o.q_wdata  = {q_i[NibW-2:0], 1'b0};
        res_o.rf_wdata = {f[NibW-2:0], 1'b0};
      end
      default: begin
        res_o.rf_wdata = {f[NibW-2:0], 1'b0};
      end
    endcase
  end

endmodule

// ----- src/bit_slice_alu_4bit.sv -----
// top level of the four-bit bit-slice alu
//
// one input transaction is one microinstruction: register file addresses a and
// b, direct data d, source, function and destination codes and carry in. each
// one gives exactly one output transaction carrying y and the status flags.
// both channels use valid and stall; a transaction moves on an edge where
// valid is high and stall is low.
// an accepted microinstruction waits in the execute register, where the
// register file read data arrive, and its result is then registered in the
// output register, which raises out_valid_o. throughput is one
// microinstruction per cycle while the receiver does not stall; the register
// file and q are written on the same edge the result is registered, and a
// write is bypassed to the read ports so a following microinstruction sees it.
// when the receiver stalls, the output register holds and the execute
// register keeps its item; in_stall_o rises only while both are full.
// reset clears the register file (through per-entry valid bits), q and
// both valid flags.
module bit_slice_alu_4bit
  import bsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      exec_valid_q;
  logic      exec_valid_d;
  in_item_t  exec_item_q;
  logic      out_valid_q;
  logic      out_valid_d;
  out_item_t out_item_q;
  nib_t      q_q;
  nib_t      q_d;
  nib_t      ra;
  nib_t      rb;
  alu_res_t  alu_res;
  logic      out_free;
  logic      advance;
  logic      accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = exec_valid_q && out_free;
  assign in_stall_o = exec_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  bsa_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (in_item_i.addr_a),
    .rd_addr_b_i (in_item_i.addr_b),
    .wr_en_i     (advance && alu_res.rf_we),
    .wr_addr_i   (exec_item_q.addr_b),
    .wr_data_i   (alu_res.rf_wdata),
    .rd_data_a_o (ra),
    .rd_data_b_o (rb)
  );

  bsa_alu u_alu (
    .item_i (exec_item_q),
    .ra_i   (ra),
    .rb_i   (rb),
    .q_i    (q_q),
    .res_o  (alu_res)
  );

  always_comb begin
    exec_valid_d = exec_valid_q;
    if (accept) begin
      exec_valid_d = 1'b1;
    end else if (advance) begin
      exec_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    q_d = (advance && alu_res.q_we) ? alu_res.q_wdata : q_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      q_q          <= '0;
    end else begin
      exec_valid_q <= exec_valid_d;
      out_valid_q  <= out_valid_d;
      q_q          <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      exec_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= alu_res.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
